[rtl/bocbs_pkg.sv]
// ----------------------------------------------------------------------------
// bocbs_pkg
// Shared types, constants and helpers for the battery overcurrent and bus
// select core.
// ----------------------------------------------------------------------------
`default_nettype none

package bocbs_pkg;

   typedef struct packed {
      logic [11:0] current_a;
      logic [11:0] current_b;
      logic [15:0] charger_code;
   } req_type;

   typedef struct packed {
      logic [1:0] active_side;
      logic       overcurrent;
   } rsp_type;

   // live configuration as seen by the tick logic
   typedef struct packed {
      logic [11:0] trig_counts;
      logic [11:0] rel_counts;
      logic [15:0] trig_dur_ms;
      logic [15:0] rel_dur_ms;
      logic [15:0] poll_ms;
      logic [15:0] side_sw_ms;
   } cfg_type;

   localparam logic [15:0] CHARGER_CODE = 16'hDADA;

   localparam logic [1:0] SIDE_A    = 2'd0;
   localparam logic [1:0] SIDE_B    = 2'd1;
   localparam logic [1:0] SIDE_BOTH = 2'd2;

   localparam int         ADDR_W = 5;
   localparam logic [2:0] REG_TRIG_TH  = 3'd0;
   localparam logic [2:0] REG_REL_TH   = 3'd1;
   localparam logic [2:0] REG_TRIG_DUR = 3'd2;
   localparam logic [2:0] REG_REL_DUR  = 3'd3;
   localparam logic [2:0] REG_POLL     = 3'd4;
   localparam logic [2:0] REG_SIDE_SW  = 3'd5;

   localparam logic [15:0] RST_TRIG_TH  = 16'd8000;
   localparam logic [15:0] RST_REL_TH   = 16'd6000;
   localparam logic [15:0] RST_TRIG_DUR = 16'd10;
   localparam logic [15:0] RST_REL_DUR  = 16'd100;
   localparam logic [15:0] RST_POLL     = 16'd10;
   localparam logic [15:0] RST_SIDE_SW  = 16'd10000;

   // floor(x / 1000) for 16-bit x as (x * 67109) >> 26
   localparam logic [16:0] MA_RECIP       = 17'd67109;
   localparam int          MA_RECIP_SHIFT = 26;
   localparam logic [5:0]  COUNTS_PER_AMP = 6'd34;

   function automatic logic [11:0] ma_to_counts(input logic [15:0] ma);
      logic [32:0] prod;
      logic [6:0]  amps;
      logic [12:0] counts;
      prod   = {17'd0, ma} * {16'd0, MA_RECIP};
      amps   = prod[MA_RECIP_SHIFT +: 7];
      counts = {6'd0, amps} * {7'd0, COUNTS_PER_AMP};
      return counts[11:0];
   endfunction

endpackage

`default_nettype wire

[rtl/battery_overcurrent_and_bus_select_core.sv]
// ----------------------------------------------------------------------------
// battery_overcurrent_and_bus_select_core
// Overcurrent detector with hysteresis and charging-time bus side selector,
// one poll tick per word.
//
//   channel  direction  signals                         payload
//   req      in         req_valid / req_ready           req_data  (req_type)
//   rsp      out        rsp_valid / rsp_ready           rsp_data  (rsp_type)
//   csr      in/out     csr_psel / csr_penable / ...    16-bit registers
//
// One word per cycle sustained while the result side is not stalled; an accepted word
// reaches rsp_valid through the input register, then the tick update into the result register.
// The state update with one shared 16x16 multiplier sets the rate.
// Synchronous reset restores register defaults and clears all counters.
// A stalled result holds both stages; req_ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_overcurrent_and_bus_select_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire bocbs_pkg::req_type           req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output bocbs_pkg::rsp_type                rsp_data,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [bocbs_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output logic      [31:0]                  csr_prdata,
   output logic                              csr_pready
);
   import bocbs_pkg::*;

   cfg_type cfg;
   rsp_type tick_result;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff,  in_data_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff,  out_data_in;
   logic    out_free;
   logic    adv;
   logic    req_fire;

   bocbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bocbs_tick u_tick (
      .clock  (clock),
      .reset  (reset),
      .step   (adv),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (tick_result)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign adv       = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || adv;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (adv) begin
         out_valid_in = 1'b1;
         out_data_in  = tick_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   a_every_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_valid)
      else $error("tick processed without a result word");

   a_held_word_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !adv |=> in_valid_ff && $stable(in_data_ff))
      else $error("waiting input word lost or changed");

   a_charging_side: assert property (@(posedge clock) disable iff (reset)
      adv && (in_data_ff.charger_code == CHARGER_CODE)
      |=> rsp_data.active_side != SIDE_BOTH)
      else $error("charging tick enabled both sides");

   a_normal_side: assert property (@(posedge clock) disable iff (reset)
      adv && (in_data_ff.charger_code != CHARGER_CODE)
      |=> rsp_data.active_side == SIDE_BOTH)
      else $error("non-charging tick did not enable both sides");
`endif

endmodule

`default_nettype wire

[rtl/bocbs_csr.sv]
// ----------------------------------------------------------------------------
// bocbs_csr
// Configuration registers behind the APB-style port; thresholds are kept in
// mA for readback and in converter counts for the tick logic.
// ----------------------------------------------------------------------------
`default_nettype none

module bocbs_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [bocbs_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic      [31:0]                 csr_prdata,
   output logic                             csr_pready,
   output bocbs_pkg::cfg_type               cfg
);
   import bocbs_pkg::*;

   logic [15:0] trig_th_ff,  trig_th_in;
   logic [15:0] rel_th_ff,   rel_th_in;
   logic [15:0] trig_dur_ff, trig_dur_in;
   logic [15:0] rel_dur_ff,  rel_dur_in;
   logic [15:0] poll_ff,     poll_in;
   logic [15:0] side_sw_ff,  side_sw_in;
   logic [11:0] trig_cnt_ff, trig_cnt_in;
   logic [11:0] rel_cnt_ff,  rel_cnt_in;
   logic        wr_en;
   logic [2:0]  idx;
   logic [15:0] wval;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_paddr[4:2];
   assign wval       = csr_pwdata[15:0];

   always_comb begin
      trig_th_in  = trig_th_ff;
      rel_th_in   = rel_th_ff;
      trig_dur_in = trig_dur_ff;
      rel_dur_in  = rel_dur_ff;
      poll_in     = poll_ff;
      side_sw_in  = side_sw_ff;
      trig_cnt_in = trig_cnt_ff;
      rel_cnt_in  = rel_cnt_ff;
      if (wr_en) begin
         unique case (idx)
            REG_TRIG_TH: begin
               trig_th_in  = wval;
               trig_cnt_in = ma_to_counts(wval);
            end
            REG_REL_TH: begin
               rel_th_in  = wval;
               rel_cnt_in = ma_to_counts(wval);
            end
            REG_TRIG_DUR: trig_dur_in = wval;
            REG_REL_DUR:  rel_dur_in  = wval;
            REG_POLL:     poll_in     = wval;
            REG_SIDE_SW:  side_sw_in  = wval;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_th_ff  <= RST_TRIG_TH;
         rel_th_ff   <= RST_REL_TH;
         trig_dur_ff <= RST_TRIG_DUR;
         rel_dur_ff  <= RST_REL_DUR;
         poll_ff     <= RST_POLL;
         side_sw_ff  <= RST_SIDE_SW;
         trig_cnt_ff <= ma_to_counts(RST_TRIG_TH);
         rel_cnt_ff  <= ma_to_counts(RST_REL_TH);
      end else begin
         trig_th_ff  <= trig_th_in;
         rel_th_ff   <= rel_th_in;
         trig_dur_ff <= trig_dur_in;
         rel_dur_ff  <= rel_dur_in;
         poll_ff     <= poll_in;
         side_sw_ff  <= side_sw_in;
         trig_cnt_ff <= trig_cnt_in;
         rel_cnt_ff  <= rel_cnt_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_TRIG_TH:  csr_prdata = {16'd0, trig_th_ff};
         REG_REL_TH:   csr_prdata = {16'd0, rel_th_ff};
         REG_TRIG_DUR: csr_prdata = {16'd0, trig_dur_ff};
         REG_REL_DUR:  csr_prdata = {16'd0, rel_dur_ff};
         REG_POLL:     csr_prdata = {16'd0, poll_ff};
         REG_SIDE_SW:  csr_prdata = {16'd0, side_sw_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   assign cfg.trig_counts = trig_cnt_ff;
   assign cfg.rel_counts  = rel_cnt_ff;
   assign cfg.trig_dur_ms = trig_dur_ff;
   assign cfg.rel_dur_ms  = rel_dur_ff;
   assign cfg.poll_ms     = poll_ff;
   assign cfg.side_sw_ms  = side_sw_ff;

endmodule

`default_nettype wire

[rtl/bocbs_tick.sv]
// ----------------------------------------------------------------------------
// bocbs_tick
// Per-tick state update: charge timer and side toggle, spike and recover
// counters, overcurrent flag with hysteresis.
// ----------------------------------------------------------------------------
`default_nettype none

module bocbs_tick (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire bocbs_pkg::req_type item,
   input  wire bocbs_pkg::cfg_type cfg,
   output bocbs_pkg::rsp_type      result
);
   import bocbs_pkg::*;

   logic [15:0] spike_ff,  spike_in;
   logic [15:0] recover_ff, recover_in;
   logic [15:0] charge_ff, charge_in;
   logic        side_b_ff, side_b_in;
   logic        flag_ff,   flag_in;

   logic        charging;
   logic        spike_hit;
   logic        all_low;
   logic [15:0] spike_inc;
   logic [15:0] recover_inc;
   logic [15:0] charge_inc;
   logic [15:0] mul_cnt;
   logic [15:0] limit;
   logic [31:0] elapsed;
   logic        reach;
   logic        exceed;

   assign charging    = item.charger_code == CHARGER_CODE;
   assign spike_hit   = (item.current_a >= cfg.trig_counts) ||
                        (item.current_b >= cfg.trig_counts);
   assign all_low     = (item.current_a <= cfg.rel_counts) &&
                        (item.current_b <= cfg.rel_counts);
   assign spike_inc   = (spike_ff == 16'hFFFF)   ? spike_ff   : spike_ff + 16'd1;
   assign recover_inc = (recover_ff == 16'hFFFF) ? recover_ff : recover_ff + 16'd1;
   assign charge_inc  = (charge_ff == 16'hFFFF)  ? charge_ff  : charge_ff + 16'd1;

   // one shared multiplier for whichever duration applies this tick
   always_comb begin
      priority if (charging) begin
         mul_cnt = charge_inc;
         limit   = cfg.side_sw_ms;
      end else if (spike_hit) begin
         mul_cnt = spike_inc;
         limit   = cfg.trig_dur_ms;
      end else begin
         mul_cnt = recover_inc;
         limit   = cfg.rel_dur_ms;
      end
   end

   assign elapsed = {16'd0, mul_cnt} * {16'd0, cfg.poll_ms};
   assign reach   = elapsed >= {16'd0, limit};
   assign exceed  = elapsed >  {16'd0, limit};

   always_comb begin
      spike_in   = spike_ff;
      recover_in = recover_ff;
      charge_in  = charge_ff;
      side_b_in  = side_b_ff;
      flag_in    = flag_ff;
      priority if (charging) begin
         if (exceed) begin
            side_b_in = !side_b_ff;
            charge_in = 16'd0;
         end else begin
            charge_in = charge_inc;
         end
      end else if (spike_hit) begin
         spike_in   = spike_inc;
         recover_in = 16'd0;
         if (reach) begin
            flag_in = 1'b1;
         end
      end else begin
         recover_in = recover_inc;
         if (all_low) begin
            spike_in = 16'd0;
         end
         if (reach) begin
            flag_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spike_ff   <= 16'd0;
         recover_ff <= 16'd0;
         charge_ff  <= 16'd0;
         side_b_ff  <= 1'b0;
         flag_ff    <= 1'b0;
      end else if (step) begin
         spike_ff   <= spike_in;
         recover_ff <= recover_in;
         charge_ff  <= charge_in;
         side_b_ff  <= side_b_in;
         flag_ff    <= flag_in;
      end
   end

   always_comb begin
      if (charging) begin
         result.active_side = side_b_in ? SIDE_B : SIDE_A;
      end else begin
         result.active_side = SIDE_BOTH;
      end
      result.overcurrent = flag_in;
   end

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the battery overcurrent and bus select core one poll tick at a time.
// A predictor tracks the spike, recover and charge counters and the
// configuration, and each result word is compared field by field with the
// oldest prediction. Directed ticks cover threshold edges, charging mode and
// side toggling. Runs with a zero poll period cover the zero-duration cases.
// Random runs use several register settings and different idle patterns on
// both channels, plus one long result stall.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bocbs_pkg::*;

   localparam logic [2:0] REG_SPARE_6 = 3'd6;
   localparam logic [2:0] REG_SPARE_7 = 3'd7;
   localparam int         MILLIAMPS_PER_AMP = 1000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   battery_overcurrent_and_bus_select_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor copy of the registers
   logic [15:0] cfg_trig_ma    = RST_TRIG_TH;
   logic [15:0] cfg_rel_ma     = RST_REL_TH;
   logic [15:0] cfg_trig_dur   = RST_TRIG_DUR;
   logic [15:0] cfg_rel_dur    = RST_REL_DUR;
   logic [15:0] cfg_poll_ms    = RST_POLL;
   logic [15:0] cfg_side_sw_ms = RST_SIDE_SW;

   // predictor copy of the detector state
   logic [15:0] spike_ticks   = '0;
   logic [15:0] recover_ticks = '0;
   logic [15:0] charge_ticks  = '0;
   logic        on_side_b     = 1'b0;
   logic        oc_latched    = 1'b0;

   rsp_type     expected_words[$];
   rsp_type     expected_word;

   int          send_idle_pct = 22;
   int          recv_idle_pct = 63;
   int          hold_len = 0;
   int          hold_seq = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   int          mismatches = 0;
   int          words_sent = 0;
   int          results_seen = 0;
   int          regs_written = 0;

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [31:0] ticks_to_ms(input logic [15:0] n);
      return {16'd0, n} * {16'd0, cfg_poll_ms};
   endfunction

   function automatic logic [31:0] ma_counts(input logic [15:0] ma);
      return ({16'd0, ma} / MILLIAMPS_PER_AMP) * {26'd0, COUNTS_PER_AMP};
   endfunction

   function automatic rsp_type predict_tick(input req_type w);
      rsp_type     r;
      logic [31:0] trig;
      logic [31:0] rel;
      trig = ma_counts(cfg_trig_ma);
      rel  = ma_counts(cfg_rel_ma);
      if (w.charger_code == CHARGER_CODE) begin
         charge_ticks = sat_inc16(charge_ticks);
         if (ticks_to_ms(charge_ticks) > {16'd0, cfg_side_sw_ms}) begin
            on_side_b    = !on_side_b;
            charge_ticks = '0;
         end
         r.active_side = on_side_b ? SIDE_B : SIDE_A;
      end else begin
         r.active_side = SIDE_BOTH;
         if ({20'd0, w.current_a} >= trig || {20'd0, w.current_b} >= trig) begin
            spike_ticks   = sat_inc16(spike_ticks);
            recover_ticks = '0;
            if (ticks_to_ms(spike_ticks) >= {16'd0, cfg_trig_dur})
               oc_latched = 1'b1;
         end else begin
            recover_ticks = sat_inc16(recover_ticks);
            if ({20'd0, w.current_a} <= rel && {20'd0, w.current_b} <= rel)
               spike_ticks = '0;
            if (ticks_to_ms(recover_ticks) >= {16'd0, cfg_rel_dur})
               oc_latched = 1'b0;
         end
      end
      r.overcurrent = oc_latched;
      return r;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("testbench failed");
      $finish;
   end

   // result side ready, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // prediction on accepted ticks, comparison on accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: side %0d overcurrent %0d",
                           rsp_data.active_side, rsp_data.overcurrent);
            end else begin
               expected_word = expected_words.pop_front();
               if (rsp_data.active_side !== expected_word.active_side ||
                   rsp_data.overcurrent !== expected_word.overcurrent) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("word %0d: side exp %0d got %0d, overcurrent exp %0d got %0d",
                              results_seen, expected_word.active_side, rsp_data.active_side,
                              expected_word.overcurrent, rsp_data.overcurrent);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_words.push_back(predict_tick(req_data));
            words_sent++;
         end
      end
   end

   task automatic send_word(input req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_tick(input logic [11:0] a, input logic [11:0] b,
                            input logic [15:0] code);
      req_type w;
      w.current_a    = a;
      w.current_b    = b;
      w.charger_code = code;
      send_word(w);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_TRIG_TH:  cfg_trig_ma    = value;
         REG_REL_TH:   cfg_rel_ma     = value;
         REG_TRIG_DUR: cfg_trig_dur   = value;
         REG_REL_DUR:  cfg_rel_dur    = value;
         REG_POLL:     cfg_poll_ms    = value;
         REG_SIDE_SW:  cfg_side_sw_ms = value;
         default: ;
      endcase
      regs_written++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      // readback of the register just written
      if (csr_prdata !== ((idx <= REG_SIDE_SW) ? {16'd0, value} : 32'd0)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("register %0d: readback exp %0h got %0h", idx,
                     ((idx <= REG_SIDE_SW) ? {16'd0, value} : 32'd0), csr_prdata);
      end
   endtask

   function automatic logic [15:0] pick_setting(input int typical);
      int roll;
      roll = $urandom_range(9);
      if (roll == 0)
         return 16'd0;
      if (roll == 1)
         return 16'hFFFF;
      return 16'($urandom_range(typical));
   endfunction

   function automatic logic [11:0] near_level(input logic [31:0] level);
      int v;
      v = int'(level) + int'($urandom_range(2)) - 1;
      if (v < 0)
         v = 0;
      if (v > 4095)
         v = 4095;
      return v[11:0];
   endfunction

   function automatic logic [11:0] pick_current;
      logic [31:0] trig;
      logic [31:0] rel;
      trig = ma_counts(cfg_trig_ma);
      rel  = ma_counts(cfg_rel_ma);
      case ($urandom_range(7))
         0:       return 12'd0;
         1:       return 12'hFFF;
         2, 3:    return 12'($urandom);
         4:       return near_level(trig);
         5:       return near_level(rel);
         6:       return near_level($urandom_range(rel, trig));
         default: return near_level($urandom_range(trig));
      endcase
   endfunction

   // reset settings: threshold edges, charging hold and release count
   task automatic test_directed_ticks;
      int k;
      send_tick(12'd0, 12'd0, 16'h0000);
      send_tick(12'hFFF, 12'd0, 16'hFFFF);
      send_tick(12'd271, 12'd271, 16'h2525);
      send_tick(12'd0, 12'd272, 16'h0001);
      send_tick(12'd205, 12'd204, 16'h8000);
      send_tick(12'd204, 12'd204, 16'h7FFF);
      send_tick(12'd0, 12'hFFF, CHARGER_CODE);
      send_tick(12'hFFF, 12'hFFF, CHARGER_CODE);
      send_tick(12'd0, 12'd0, CHARGER_CODE ^ 16'h0001);
      send_tick(12'd0, 12'd0, CHARGER_CODE ^ 16'h8000);
      for (k = 0; k < 11; k++)
         send_tick(12'd100, 12'(k * 24), 16'($urandom));
      drain();
   endtask

   task automatic test_side_switch;
      int k;
      write_reg(REG_POLL, 16'd10);
      write_reg(REG_SIDE_SW, 16'd30);
      for (k = 0; k < 6; k++)
         send_tick(12'($urandom), 12'($urandom), CHARGER_CODE);
      send_tick(12'd0, 12'd0, 16'h1234);
      send_tick(12'hFFF, 12'd0, 16'hDADB);
      for (k = 0; k < 5; k++)
         send_tick(12'd0, 12'd0, CHARGER_CODE);
      drain();
      write_reg(REG_SIDE_SW, 16'd0);
      for (k = 0; k < 3; k++)
         send_tick(12'd0, 12'd0, CHARGER_CODE);
      drain();
      write_reg(REG_SIDE_SW, 16'hFFFF);
      write_reg(REG_POLL, 16'hFFFF);
      for (k = 0; k < 3; k++)
         send_tick(12'd0, 12'd0, CHARGER_CODE);
      drain();
   endtask

   // result side holds off while ticks keep coming, then the sender waits
   task automatic test_input_stall;
      int      saved;
      int      k;
      req_type w;
      saved         = send_idle_pct;
      send_idle_pct = 0;
      hold_len      = 60;
      hold_seq      = hold_seq + 1;
      for (k = 0; k < 24; k++) begin
         w.current_a    = pick_current();
         w.current_b    = pick_current();
         w.charger_code = ($urandom_range(1) == 0) ? CHARGER_CODE : 16'($urandom);
         send_word(w);
      end
      send_idle_pct = saved;
      drain();
   endtask

   task automatic test_random_phases(input int send_pct, input int recv_pct,
                                     input int phases, input int per_phase);
      int      p;
      int      k;
      int      burst_left;
      logic    charging;
      req_type w;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      burst_left    = 0;
      charging      = 1'b0;
      for (p = 0; p < phases; p++) begin
         drain();
         write_reg(REG_TRIG_TH, pick_setting(20000));
         write_reg(REG_REL_TH, pick_setting(20000));
         write_reg(REG_TRIG_DUR, pick_setting(200));
         write_reg(REG_REL_DUR, pick_setting(200));
         write_reg(REG_POLL, pick_setting(30));
         write_reg(REG_SIDE_SW, pick_setting(300));
         if ($urandom_range(2) == 0)
            write_reg(($urandom_range(1) == 0) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
         for (k = 0; k < per_phase; k++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 30);
               charging   = ($urandom_range(2) == 0);
            end
            burst_left--;
            w.current_a = pick_current();
            w.current_b = pick_current();
            if (charging) begin
               case ($urandom_range(9))
                  0:       w.charger_code = CHARGER_CODE ^ (16'd1 << $urandom_range(15));
                  1:       w.charger_code = 16'($urandom);
                  default: w.charger_code = CHARGER_CODE;
               endcase
            end else begin
               w.charger_code = ($urandom_range(19) == 0) ? CHARGER_CODE : 16'($urandom);
            end
            send_word(w);
         end
      end
      drain();
   endtask

   // zero poll period keeps every duration product at zero;
   // a nonzero period afterwards shows where each counter stands
   task automatic test_zero_poll;
      int k;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      drain();
      write_reg(REG_TRIG_TH, 16'd1000);
      write_reg(REG_REL_TH, 16'd0);
      write_reg(REG_TRIG_DUR, 16'd1);
      write_reg(REG_REL_DUR, 16'd0);
      write_reg(REG_POLL, 16'd0);
      send_tick(12'd10, 12'd0, 16'h0000);
      for (k = 0; k < 20; k++)
         send_tick(12'd40, 12'd0, 16'h0000);
      drain();
      write_reg(REG_POLL, 16'd1);
      write_reg(REG_TRIG_DUR, 16'hFFFF);
      write_reg(REG_REL_DUR, 16'hFFFF);
      send_tick(12'd10, 12'd0, 16'h0000);
      send_tick(12'd0, 12'd40, 16'h0000);
      drain();
      write_reg(REG_POLL, 16'd0);
      write_reg(REG_REL_DUR, 16'd1);
      for (k = 0; k < 20; k++)
         send_tick(12'd10, 12'd10, 16'h0000);
      drain();
      write_reg(REG_POLL, 16'd1);
      write_reg(REG_REL_DUR, 16'hFFFF);
      send_tick(12'd10, 12'd0, 16'h0000);
      drain();
      write_reg(REG_POLL, 16'd0);
      write_reg(REG_SIDE_SW, 16'hFFFE);
      for (k = 0; k < 20; k++)
         send_tick(12'd0, 12'd0, CHARGER_CODE);
      drain();
      write_reg(REG_POLL, 16'd1);
      send_tick(12'd0, 12'd0, CHARGER_CODE);
      send_tick(12'd0, 12'd0, CHARGER_CODE);
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      drain();
      test_directed_ticks();
      test_side_switch();
      test_input_stall();
      test_random_phases(22, 63, 4, 30);
      test_random_phases(63, 22, 4, 30);
      test_random_phases(0, 0, 4, 30);
      test_zero_poll();
      drain();
      repeat (8) @(posedge clock);
      if (expected_words.size() != 0) begin
         mismatches++;
         $display("%0d expected words never arrived", expected_words.size());
      end
      $display("%0d ticks and %0d result words over %0d register writes,",
               words_sent, results_seen, regs_written);
      $display("with directed edges, side toggling, a long stall, random settings and zero poll");
      if (mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("testbench failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
